@@ src/mff_pkg.sv @@
// Package for the message fragment framer: sizes, framing marks, the byte
// position type and the job record that travels from the front to the back.
// No dependencies.
`timescale 1ns / 1ps

package mff_pkg;

   localparam int FRAG_BYTES    = 10240;
   localparam int MAX_FRAGMENTS = 255;
   localparam int LEN_W         = 22;
   localparam int OFFSET_W      = 14;
   localparam int FRAGLEN_W     = 16;

   localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_FRAGMENTS * FRAG_BYTES);
   localparam logic [LEN_W-1:0] FRAG_LEN = LEN_W'(FRAG_BYTES);
   localparam logic [OFFSET_W-1:0] FRAG_OFFSET = OFFSET_W'(FRAG_BYTES);

   // FRAG_BYTES is 2048 times 5; the divide by 5 is a reciprocal multiply.
   localparam int FRAG_SHIFT   = 11;
   localparam int QUOT_W       = LEN_W - FRAG_SHIFT;
   localparam int RECIP_SHIFT  = 18;
   localparam logic [15:0] RECIP = 16'd52429;
   localparam int PROD_W       = QUOT_W + 16;

   localparam logic [7:0] START_MARK = 8'hF1;
   localparam logic [7:0] END_MARK   = 8'hF2;

   typedef enum logic [2:0] {
      PH_START,
      PH_LEN_HI,
      PH_LEN_LO,
      PH_SEQ,
      PH_TOTAL,
      PH_INDEX,
      PH_DATA,
      PH_END
   } phase_type;

   typedef struct packed {
      logic [7:0]            data;
      logic                  header;
      logic                  trailer;
      logic [OFFSET_W-1:0]   frag_len;
      logic [7:0]            seq;
      logic [7:0]            total;
      logic [7:0]            index;
   } job_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage

@@ src/mff_front.sv @@
// Front of the framer: accepts input items, tracks message and fragment state,
// and turns each payload byte into a job record. Depends on mff_pkg.
`timescale 1ns / 1ps

module mff_front
   import mff_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             accept,
   input  logic [7:0]       data_byte,
   input  logic             first_of_message,
   input  logic [LEN_W-1:0] msg_len,
   output logic             job_valid,
   output job_type          job
);

   logic [7:0]          seq_ff, seq_in;
   logic [7:0]          total_ff, total_in;
   logic [7:0]          index_ff, index_in;
   logic [LEN_W-1:0]    remaining_ff, remaining_in;
   logic [OFFSET_W-1:0] offset_ff, offset_in;

   logic [LEN_W-1:0]    len_fix;
   logic [LEN_W-1:0]    len_m1;
   logic [PROD_W-1:0]   prod;
   logic [7:0]          total_new;
   logic [LEN_W-1:0]    rem_sel;
   logic [OFFSET_W-1:0] off_sel;
   logic [7:0]          index_sel;
   logic [7:0]          seq_sel;
   logic [7:0]          total_sel;
   logic [LEN_W-1:0]    rem_next;
   logic [OFFSET_W-1:0] off_next;
   logic                trailer;

   always_comb begin
      len_fix = (msg_len == '0) ? LEN_W'(1) : msg_len;
      if (len_fix > MAX_LEN) begin
         len_fix = MAX_LEN;
      end
      len_m1    = len_fix - LEN_W'(1);
      prod      = PROD_W'(len_m1[LEN_W-1:FRAG_SHIFT]) * PROD_W'(RECIP);
      total_new = prod[RECIP_SHIFT+7:RECIP_SHIFT] + 8'd1;

      if (first_of_message) begin
         rem_sel   = len_fix;
         off_sel   = '0;
         index_sel = '0;
         total_sel = total_new;
         seq_sel   = (remaining_ff != '0) ? seq_ff + 8'd1 : seq_ff;
      end else begin
         rem_sel   = remaining_ff;
         off_sel   = offset_ff;
         index_sel = index_ff;
         total_sel = total_ff;
         seq_sel   = seq_ff;
      end

      rem_next = rem_sel - LEN_W'(1);
      off_next = off_sel + OFFSET_W'(1);
      trailer  = (rem_next == '0) || (off_next >= FRAG_OFFSET);

      job.data     = data_byte;
      job.header   = (off_sel == '0);
      job.trailer  = trailer;
      job.frag_len = (rem_sel < FRAG_LEN) ? rem_sel[OFFSET_W-1:0] : FRAG_OFFSET;
      job.seq      = seq_sel;
      job.total    = total_sel;
      job.index    = index_sel;
      job_valid    = accept && (rem_sel != '0);

      seq_in       = seq_ff;
      total_in     = total_ff;
      index_in     = index_ff;
      remaining_in = remaining_ff;
      offset_in    = offset_ff;
      if (job_valid) begin
         total_in     = total_sel;
         remaining_in = rem_next;
         offset_in    = off_next;
         index_in     = index_sel;
         seq_in       = seq_sel;
         if (trailer) begin
            offset_in = '0;
            index_in  = index_sel + 8'd1;
            if (rem_next == '0) begin
               seq_in   = seq_sel + 8'd1;
               index_in = '0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seq_ff       <= '0;
         total_ff     <= '0;
         index_ff     <= '0;
         remaining_ff <= '0;
         offset_ff    <= '0;
      end else begin
         seq_ff       <= seq_in;
         total_ff     <= total_in;
         index_ff     <= index_in;
         remaining_ff <= remaining_in;
         offset_ff    <= offset_in;
      end
   end

endmodule

@@ src/mff_job_queue.sv @@
// Two-entry queue of job records between the front and the back of the framer.
// Depends on mff_pkg.
`timescale 1ns / 1ps

module mff_job_queue
   import mff_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             wr_en,
   input  job_type          wr_job,
   input  logic             rd_en,
   output job_type          rd_job,
   output queue_status_type status
);

   job_type    entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   always_comb begin
      status.full  = (count_ff == 2'd2);
      status.empty = (count_ff == 2'd0);
      rd_job       = entry_ff[rd_ptr_ff];
      wr_ptr_in    = wr_en ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in    = rd_en ? ~rd_ptr_ff : rd_ptr_ff;
      count_in     = count_ff + 2'(wr_en) - 2'(rd_en);
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         entry_ff[wr_ptr_ff] <= wr_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

@@ src/mff_back.sv @@
// Back of the framer: walks the head job byte by byte (header, payload,
// trailer) into an output register. Depends on mff_pkg.
`timescale 1ns / 1ps

module mff_back
   import mff_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       job_avail,
   input  job_type    job,
   output logic       job_done,
   output logic       rsp_empty,
   input  logic       rsp_pop,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_fragment_end,
   output logic       rsp_run_last
);

   phase_type  phase_ff, phase_in;
   phase_type  phase_eff;
   logic       valid_ff, valid_in;
   logic [7:0] byte_ff, byte_in;
   logic       end_ff, end_in;
   logic       last_ff, last_in;
   logic       load;
   logic       last;
   logic [FRAGLEN_W-1:0] frag_len16;

   always_comb begin
      frag_len16 = FRAGLEN_W'(job.frag_len);
      phase_eff  = (phase_ff == PH_START && !job.header) ? PH_DATA : phase_ff;
      last       = (phase_eff == PH_END) || (phase_eff == PH_DATA && !job.trailer);
      load       = job_avail && (!valid_ff || rsp_pop);
      job_done   = load && last;

      case (phase_eff)
         PH_START:  byte_in = START_MARK;
         PH_LEN_HI: byte_in = frag_len16[15:8];
         PH_LEN_LO: byte_in = frag_len16[7:0];
         PH_SEQ:    byte_in = job.seq;
         PH_TOTAL:  byte_in = job.total;
         PH_INDEX:  byte_in = job.index;
         PH_DATA:   byte_in = job.data;
         PH_END:    byte_in = END_MARK;
         default:   byte_in = START_MARK;
      endcase
      end_in  = (phase_eff == PH_END);
      last_in = last;

      phase_in = phase_ff;
      if (load) begin
         phase_in = last ? PH_START : phase_type'(phase_eff + 3'd1);
      end
      valid_in = load || (valid_ff && !rsp_pop);

      rsp_empty        = !valid_ff;
      rsp_out_byte     = byte_ff;
      rsp_fragment_end = end_ff;
      rsp_run_last     = last_ff;
   end

   always_ff @(posedge clock) begin
      if (load) begin
         byte_ff <= byte_in;
         end_ff  <= end_in;
         last_ff <= last_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_START;
         valid_ff <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         valid_ff <= valid_in;
      end
   end

endmodule

@@ src/message_fragment_framer.sv @@
// Top level of the message fragment framer: front, job queue and back.
// Depends on mff_pkg, mff_front, mff_job_queue and mff_back.
//
//   Channel   Ports                                          Direction
//   request   req_push req_full req_data_byte                in
//             req_first_of_message req_msg_len
//   response  rsp_empty rsp_pop rsp_out_byte                 out
//             rsp_fragment_end rsp_run_last
//
// The front takes one item per cycle while the two-entry job queue has room.
// The back sends one framed byte per cycle while rsp_pop takes them: an item
// yields 1 to 8 framed bytes (7 or 8 at a fragment's first byte), through the
// single output byte register; a mid-fragment payload byte yields just one.
// Synchronous reset clears all message state and both queues.
// Output stalls fill the job queue and then raise req_full.
`timescale 1ns / 1ps

module message_fragment_framer
   import mff_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_push,
   output logic             req_full,
   input  logic [7:0]       req_data_byte,
   input  logic             req_first_of_message,
   input  logic [LEN_W-1:0] req_msg_len,
   output logic             rsp_empty,
   input  logic             rsp_pop,
   output logic [7:0]       rsp_out_byte,
   output logic             rsp_fragment_end,
   output logic             rsp_run_last
);

   logic             accept;
   logic             job_valid;
   job_type          front_job;
   job_type          head_job;
   logic             job_done;
   queue_status_type q_status;

   assign req_full = q_status.full;
   assign accept   = req_push && !q_status.full;

   mff_front u_front (
      .clock            (clock),
      .reset            (reset),
      .accept           (accept),
      .data_byte        (req_data_byte),
      .first_of_message (req_first_of_message),
      .msg_len          (req_msg_len),
      .job_valid        (job_valid),
      .job              (front_job)
   );

   mff_job_queue u_queue (
      .clock  (clock),
      .reset  (reset),
      .wr_en  (job_valid),
      .wr_job (front_job),
      .rd_en  (job_done),
      .rd_job (head_job),
      .status (q_status)
   );

   mff_back u_back (
      .clock            (clock),
      .reset            (reset),
      .job_avail        (!q_status.empty),
      .job              (head_job),
      .job_done         (job_done),
      .rsp_empty        (rsp_empty),
      .rsp_pop          (rsp_pop),
      .rsp_out_byte     (rsp_out_byte),
      .rsp_fragment_end (rsp_fragment_end),
      .rsp_run_last     (rsp_run_last)
   );

`ifndef SYNTHESIS
   a_trailer_closes_run: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_fragment_end) |-> (rsp_out_byte == END_MARK && rsp_run_last))
      else $error("trailer item is not the last of its run");

   a_queue_status: assert property (@(posedge clock) disable iff (reset)
      !(q_status.full && q_status.empty))
      else $error("job queue is both full and empty");

   a_reset_clears: assert property (@(posedge clock)
      reset |=> (rsp_empty && q_status.empty))
      else $error("reset did not clear the queues");

   a_done_needs_job: assert property (@(posedge clock) disable iff (reset)
      job_done |-> !q_status.empty)
      else $error("job retired from an empty queue");
`endif

endmodule

@@ bench/tb.sv @@
// Testbench for message_fragment_framer: directed and random items checked field by field
// against a behavioral framer kept in this file. Depends on mff_pkg and the framer RTL.
`timescale 1ns / 1ps

module tb
   import mff_pkg::*;
;

   localparam int unsigned SATURATED_LEN = MAX_FRAGMENTS * FRAG_BYTES;
   localparam int RANDOM_ITEMS = 210;
   localparam int SETTLE_CYCLES = 20;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       fragment_end;
      logic       run_last;
   } framed_byte_type;

   typedef struct packed {
      logic [7:0]       data;
      logic             first;
      logic [LEN_W-1:0] len;
      logic             typed;
      logic [3:0]       n_typed;
      logic [63:0]      typed_bytes;
      logic             closes;
   } stim_row_type;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_push = 1'b0;
   logic             req_full;
   logic [7:0]       req_data_byte = 8'h00;
   logic             req_first_of_message = 1'b0;
   logic [LEN_W-1:0] req_msg_len = '0;
   logic             rsp_empty;
   logic             rsp_pop = 1'b0;
   logic [7:0]       rsp_out_byte;
   logic             rsp_fragment_end;
   logic             rsp_run_last;

   logic [7:0]          seq_num = '0;
   logic [7:0]          frag_total = '0;
   logic [7:0]          frag_index = '0;
   logic [LEN_W-1:0]    remaining = '0;
   logic [OFFSET_W-1:0] offset = '0;

   framed_byte_type item_burst[$];
   framed_byte_type frame_bytes_due[$];
   stim_row_type    directed_rows[$];
   bit              send_quiet = 1'b0;
   bit              take_quiet = 1'b0;
   int              failures = 0;

   message_fragment_framer DUT (
      .clock(clock),
      .reset(reset),
      .req_push(req_push),
      .req_full(req_full),
      .req_data_byte(req_data_byte),
      .req_first_of_message(req_first_of_message),
      .req_msg_len(req_msg_len),
      .rsp_empty(rsp_empty),
      .rsp_pop(rsp_pop),
      .rsp_out_byte(rsp_out_byte),
      .rsp_fragment_end(rsp_fragment_end),
      .rsp_run_last(rsp_run_last)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic int draw_gap(inout bit quiet);
      if ($urandom_range(0, 29) == 0) quiet = !quiet;
      return quiet ? 0 : $urandom_range(0, 10);
   endfunction

   function automatic stim_row_type payload_row(input logic [7:0] data, input logic first,
         input logic [LEN_W-1:0] len);
      stim_row_type row;
      row = '0;
      row.data = data;
      row.first = first;
      row.len = len;
      return row;
   endfunction

   task automatic add_row(input logic [7:0] data, input logic first,
         input logic [LEN_W-1:0] len, input logic typed, input logic [3:0] n_typed,
         input logic [63:0] typed_bytes, input logic closes);
      stim_row_type row;
      row = payload_row(data, first, len);
      row.typed = typed;
      row.n_typed = n_typed;
      row.typed_bytes = typed_bytes;
      row.closes = closes;
      directed_rows.push_back(row);
   endtask

   task automatic add_framed(input logic [7:0] value, input logic closing);
      framed_byte_type fb;
      fb.out_byte = value;
      fb.fragment_end = closing;
      fb.run_last = 1'b0;
      item_burst.push_back(fb);
   endtask

   task automatic advance_sequence();
      seq_num = seq_num + 8'd1;
   endtask

   task automatic frame_payload_byte(input logic [7:0] data, input logic first,
         input logic [LEN_W-1:0] len);
      int unsigned length;
      int unsigned frag_len;
      item_burst.delete();
      if (first) begin
         if (remaining != 0) advance_sequence();
         length = len;
         if (length == 0) length = 1;
         if (length > SATURATED_LEN) length = SATURATED_LEN;
         remaining = LEN_W'(length);
         frag_total = 8'((length + FRAG_BYTES - 1) / FRAG_BYTES);
         frag_index = '0;
         offset = '0;
      end
      if (remaining == 0) return;
      if (offset == 0) begin
         frag_len = (remaining < FRAG_BYTES) ? remaining : FRAG_BYTES;
         add_framed(START_MARK, 1'b0);
         add_framed(frag_len[15:8], 1'b0);
         add_framed(frag_len[7:0], 1'b0);
         add_framed(seq_num, 1'b0);
         add_framed(frag_total, 1'b0);
         add_framed(frag_index, 1'b0);
      end
      add_framed(data, 1'b0);
      offset = offset + OFFSET_W'(1);
      remaining = remaining - LEN_W'(1);
      if (remaining == 0 || offset >= FRAG_BYTES) begin
         add_framed(END_MARK, 1'b1);
         offset = '0;
         frag_index = frag_index + 8'd1;
         if (remaining == 0) begin
            advance_sequence();
            frag_index = '0;
         end
      end
      item_burst[item_burst.size() - 1].run_last = 1'b1;
   endtask

   task automatic push_item(input stim_row_type row);
      int gap;
      framed_byte_type fb;
      gap = draw_gap(send_quiet);
      if (gap > 0) begin
         req_push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_push <= 1'b1;
      req_data_byte <= row.data;
      req_first_of_message <= row.first;
      req_msg_len <= row.len;
      do @(posedge clock); while (req_full);
      frame_payload_byte(row.data, row.first, row.len);
      if (row.typed) begin
         item_burst.delete();
         for (int k = 0; k < row.n_typed; k++) begin
            fb.out_byte = row.typed_bytes[63 - 8 * k -: 8];
            fb.run_last = (k == row.n_typed - 1);
            fb.fragment_end = row.closes && fb.run_last;
            item_burst.push_back(fb);
         end
      end
      foreach (item_burst[k]) frame_bytes_due.push_back(item_burst[k]);
   endtask

   initial begin
      int gap;
      wait (reset == 1'b0);
      forever begin
         gap = draw_gap(take_quiet);
         if (gap > 0) begin
            rsp_pop <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_pop <= 1'b1;
         do @(posedge clock); while (rsp_empty);
      end
   end

   always @(posedge clock) begin : check_results
      framed_byte_type want;
      if (!reset && rsp_pop && !rsp_empty) begin
         if (frame_bytes_due.size() == 0) begin
            $error("unexpected item: out_byte %h fragment_end %b run_last %b",
                   rsp_out_byte, rsp_fragment_end, rsp_run_last);
            failures++;
         end else begin
            want = frame_bytes_due.pop_front();
            if (rsp_out_byte !== want.out_byte) begin
               $error("out_byte: expected %h, actual %h", want.out_byte, rsp_out_byte);
               failures++;
            end
            if (rsp_fragment_end !== want.fragment_end) begin
               $error("fragment_end: expected %b, actual %b",
                      want.fragment_end, rsp_fragment_end);
               failures++;
            end
            if (rsp_run_last !== want.run_last) begin
               $error("run_last: expected %b, actual %b", want.run_last, rsp_run_last);
               failures++;
            end
         end
      end
   end

   initial begin
      #40ms;
      $display("FAIL");
      $finish;
   end

   initial begin
      int random_items;
      int pick;
      int size_pick;
      int msg_size;
      int bytes_to_send;
      logic [LEN_W-1:0] msg_len;
      random_items = 0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      add_row(8'h00, 1'b0, 22'h3FFFFF, 1'b1, 4'd0, 64'h0, 1'b0);
      add_row(8'hFF, 1'b1, 22'd0, 1'b1, 4'd8, 64'hF1_00_01_00_01_00_FF_F2, 1'b1);
      add_row(8'h00, 1'b1, 22'd1, 1'b1, 4'd8, 64'hF1_00_01_01_01_00_00_F2, 1'b1);
      add_row(8'hA5, 1'b1, 22'd3, 1'b1, 4'd7, 64'hF1_00_03_02_01_00_A5_00, 1'b0);
      add_row(8'h5A, 1'b0, 22'h2AAAAA, 1'b1, 4'd1, 64'h5A_00_00_00_00_00_00_00, 1'b0);
      add_row(8'h3C, 1'b0, 22'h155555, 1'b1, 4'd2, 64'h3C_F2_00_00_00_00_00_00, 1'b1);
      add_row(8'h11, 1'b1, 22'h3FFFFF, 1'b1, 4'd7, 64'hF1_28_00_03_FF_00_11_00, 1'b0);
      add_row(8'h22, 1'b0, 22'd0, 1'b0, 4'd0, 64'h0, 1'b0);
      add_row(8'h33, 1'b1, 22'd2, 1'b1, 4'd7, 64'hF1_00_02_04_01_00_33_00, 1'b0);
      add_row(8'h44, 1'b0, 22'd9, 1'b1, 4'd2, 64'h44_F2_00_00_00_00_00_00, 1'b1);
      add_row(8'h55, 1'b1, 22'd2611200, 1'b1, 4'd7, 64'hF1_28_00_05_FF_00_55_00, 1'b0);
      add_row(8'h66, 1'b1, 22'd2611201, 1'b1, 4'd7, 64'hF1_28_00_06_FF_00_66_00, 1'b0);
      add_row(8'h77, 1'b1, 22'd10240, 1'b1, 4'd7, 64'hF1_28_00_07_01_00_77_00, 1'b0);
      add_row(8'h88, 1'b1, 22'd10241, 1'b1, 4'd7, 64'hF1_28_00_08_02_00_88_00, 1'b0);
      add_row(8'h00, 1'b1, 22'd2, 1'b1, 4'd7, 64'hF1_00_02_09_01_00_00_00, 1'b0);
      add_row(8'hFF, 1'b0, 22'd0, 1'b1, 4'd2, 64'hFF_F2_00_00_00_00_00_00, 1'b1);
      add_row(8'hAB, 1'b0, 22'd0, 1'b1, 4'd0, 64'h0, 1'b0);
      add_row(8'h01, 1'b1, 22'd255, 1'b0, 4'd0, 64'h0, 1'b0);
      add_row(8'hC3, 1'b1, 22'd256, 1'b0, 4'd0, 64'h0, 1'b0);
      add_row(8'h7E, 1'b1, 22'd1, 1'b0, 4'd0, 64'h0, 1'b0);
      add_row(8'h96, 1'b0, 22'h3FFFFF, 1'b0, 4'd0, 64'h0, 1'b0);
      foreach (directed_rows[r]) push_item(directed_rows[r]);

      while (random_items < RANDOM_ITEMS) begin
         pick = $urandom_range(0, 99);
         bytes_to_send = 0;
         if (pick < 6) begin
            if (remaining == 0) begin
               push_item(payload_row(8'($urandom), 1'b0, LEN_W'($urandom)));
               random_items++;
            end
         end else if (pick < 9) begin
            msg_len = LEN_W'($urandom_range(SATURATED_LEN + 1, (1 << LEN_W) - 1));
            bytes_to_send = $urandom_range(1, 4);
         end else begin
            size_pick = $urandom_range(0, 99);
            if (size_pick < 80) msg_size = 1;
            else if (size_pick < 97) msg_size = $urandom_range(2, 8);
            else msg_size = $urandom_range(9, 60);
            msg_len = (msg_size == 1 && $urandom_range(0, 3) == 0) ? '0 : LEN_W'(msg_size);
            bytes_to_send = msg_size;
            if (pick < 15 && msg_size > 1) bytes_to_send = $urandom_range(1, msg_size - 1);
         end
         for (int b = 0; b < bytes_to_send; b++) begin
            push_item(payload_row(8'($urandom), b == 0,
                                  (b == 0) ? msg_len : LEN_W'($urandom)));
            random_items++;
         end
      end
      req_push <= 1'b0;

      while (frame_bytes_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (failures == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

@@ message_fragment_framer.f @@
src/mff_pkg.sv
src/mff_front.sv
src/mff_job_queue.sv
src/mff_back.sv
src/message_fragment_framer.sv
bench/tb.sv
